>>> sv/shfd_pkg.sv
// Package: shared types and constants for the sync-header frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package shfd_pkg;

   localparam int HdrLen   = 11;   // header bytes in one window
   localparam int ChainLen = 14;   // input cells in the chain

   localparam logic [3:0] LastIdx = 4'(HdrLen - 1);

   localparam logic [7:0] SyncByte0 = 8'hA5;
   localparam logic [7:0] SyncByte1 = 8'h06;
   localparam logic [7:0] SyncByte2 = 8'h01;

   // one input transfer as it travels down the chain
   typedef struct packed {
      logic       flush;
      logic [7:0] data;
   } shfd_entry_type;

   typedef enum logic [1:0] {
      KIND_FRAME    = 2'd0,
      KIND_RESYNC   = 2'd1,
      KIND_OVERSIZE = 2'd2
   } shfd_kind_type;

   typedef enum logic [3:0] {
      MODE_HUNT    = 4'b0001,
      MODE_HEADER  = 4'b0010,
      MODE_PAYLOAD = 4'b0100,
      MODE_DISCARD = 4'b1000
   } shfd_mode_type;

   // one result as held in the output register
   typedef struct packed {
      logic          last;
      logic          frame_end;
      logic          frame_first;
      shfd_kind_type kind;
      logic [15:0]   payload_length;
      logic [7:0]    out_byte;
   } shfd_result_type;

endpackage

`default_nettype wire

>>> sv/shfd_cell.sv
// One cell of the input chain: holds one transfer and pulls from the cell above.
`timescale 1ns / 1ps
`default_nettype none

module shfd_cell
   import shfd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           move_in,    // cell below is taking or emptying
   input  wire shfd_entry_type up_entry,
   input  wire logic           up_valid,
   output logic                move_out,   // this cell takes from above
   output shfd_entry_type      entry,
   output logic                valid
);

   logic           valid_ff, valid_in;
   shfd_entry_type entry_ff, entry_in;

   // an empty cell always takes; a full one takes when the one below moves
   assign move_out = move_in | ~valid_ff;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (move_out) begin
         valid_in = up_valid;
         entry_in = up_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

>>> sv/shfd_ctrl.sv
// Head controller: header check, frame sequencing and the result register.
`timescale 1ns / 1ps
`default_nettype none

module shfd_ctrl
   import shfd_pkg::*;
#(
   parameter int MAX_FRAME = 1024
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire shfd_entry_type  win [HdrLen],
   input  wire logic [HdrLen-1:0] win_valid,
   input  wire logic            rsp_ready,
   output logic                 drain,      // head cell consumed this cycle
   output logic                 rsp_valid,
   output shfd_result_type      rsp
);

   localparam logic [16:0] MaxFrame = 17'(MAX_FRAME);

   shfd_mode_type   mode_ff, mode_in;
   logic [3:0]      idx_ff, idx_in;
   logic [15:0]     len_ff, len_in;
   logic [15:0]     left_ff, left_in;
   logic            rsp_valid_ff, rsp_valid_in;
   shfd_result_type rsp_ff, rsp_in;

   logic        out_free;
   logic        load;
   logic        head_data, head_flush;
   logic        full_data, flush_ahead, prefix_ok;
   logic        sync_ok, oversize;
   logic [15:0] len_win;

   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign head_data  = win_valid[0] & ~win[0].flush;
   assign head_flush = win_valid[0] & win[0].flush;
   assign sync_ok    = (win[0].data == SyncByte0) && (win[1].data == SyncByte1)
                       && (win[2].data == SyncByte2);
   assign len_win    = {win[9].data, win[10].data};
   assign oversize   = ({1'b0, len_win} + 17'(HdrLen)) > MaxFrame;

   // window complete, or a flush sits behind data that can never fill it
   always_comb begin
      full_data   = head_data;
      prefix_ok   = head_data;
      flush_ahead = 1'b0;
      for (int k = 1; k < HdrLen; k++) begin
         full_data = full_data & win_valid[k] & ~win[k].flush;
         if (prefix_ok && win_valid[k] && win[k].flush) begin
            flush_ahead = 1'b1;
         end
         prefix_ok = prefix_ok & win_valid[k] & ~win[k].flush;
      end
   end

   always_comb begin
      drain   = 1'b0;
      load    = 1'b0;
      mode_in = mode_ff;
      idx_in  = idx_ff;
      len_in  = len_ff;
      left_in = left_ff;
      rsp_in  = rsp_ff;
      unique case (mode_ff)
         MODE_HUNT: begin
            if (head_flush) begin
               drain = 1'b1;
            end else if (full_data) begin
               if (out_free) begin
                  drain = 1'b1;
                  load  = 1'b1;
                  rsp_in.last        = 1'b1;
                  rsp_in.frame_end   = 1'b0;
                  rsp_in.frame_first = 1'b0;
                  if (!sync_ok) begin
                     rsp_in.kind           = KIND_RESYNC;
                     rsp_in.out_byte       = win[0].data;
                     rsp_in.payload_length = 16'd0;
                  end else if (oversize) begin
                     rsp_in.kind           = KIND_OVERSIZE;
                     rsp_in.out_byte       = 8'd0;
                     rsp_in.payload_length = len_win;
                     mode_in               = MODE_DISCARD;
                  end else begin
                     rsp_in.kind           = KIND_FRAME;
                     rsp_in.out_byte       = win[0].data;
                     rsp_in.payload_length = len_win;
                     rsp_in.frame_first    = 1'b1;
                     rsp_in.last           = 1'b0;
                     idx_in                = 4'd1;
                     len_in                = len_win;
                     mode_in               = MODE_HEADER;
                  end
               end
            end else if (flush_ahead) begin
               drain = 1'b1;
            end
         end
         MODE_HEADER: begin
            if (out_free) begin
               drain = 1'b1;
               load  = 1'b1;
               rsp_in.kind           = KIND_FRAME;
               rsp_in.out_byte       = win[0].data;
               rsp_in.payload_length = len_ff;
               rsp_in.frame_first    = 1'b0;
               rsp_in.last           = (idx_ff == LastIdx);
               rsp_in.frame_end      = (idx_ff == LastIdx) && (len_ff == 16'd0);
               idx_in                = idx_ff + 4'd1;
               if (idx_ff == LastIdx) begin
                  left_in = len_ff;
                  mode_in = (len_ff != 16'd0) ? MODE_PAYLOAD : MODE_HUNT;
               end
            end
         end
         MODE_PAYLOAD: begin
            if (head_flush) begin
               drain   = 1'b1;
               left_in = 16'd0;
               mode_in = MODE_HUNT;
            end else if (head_data && out_free) begin
               drain = 1'b1;
               load  = 1'b1;
               rsp_in.kind           = KIND_FRAME;
               rsp_in.out_byte       = win[0].data;
               rsp_in.payload_length = len_ff;
               rsp_in.frame_first    = 1'b0;
               rsp_in.frame_end      = (left_ff == 16'd1);
               rsp_in.last           = 1'b1;
               left_in               = left_ff - 16'd1;
               if (left_ff == 16'd1) begin
                  mode_in = MODE_HUNT;
               end
            end
         end
         MODE_DISCARD: begin
            if (head_flush) begin
               drain   = 1'b1;
               mode_in = MODE_HUNT;
            end else if (head_data) begin
               drain = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_HUNT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HUNT;
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_drain_has_head: assert property (@(posedge clock) disable iff (reset)
      drain |-> win_valid[0])
      else $error("head consumed from an empty cell");

   a_header_aligned: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HEADER) |-> win_valid[0] && !win[0].flush)
      else $error("header byte missing at chain head");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HEADER) |-> (idx_ff != 4'd0) && (idx_ff <= LastIdx))
      else $error("header index out of range");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_PAYLOAD) |-> (left_ff != 16'd0))
      else $error("payload mode with nothing left");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> sv/sync_header_frame_deframer.sv
// Top level: sync-header frame deframer, input cell chain plus head controller.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Ports      | Contents
// --------+-----+------------+--------------------------------------------
// req     | in  | req_t*     | stream bytes and flush marks
// rsp     | out | rsp_t*     | frame bytes, resync drops, oversize errors
//
// Every input transfer enters the top of a chain of ChainLen cells and falls one cell
// per cycle toward the head; the controller looks at the lowest 11 cells as the window.
// Throughput is one transfer per cycle on both sides: req_tready follows the top cell's
// move, so a full chain still takes a transfer in a cycle in which the head drains.
// The chain holds the 11-result burst of a header, which leaves at one result per cycle.
// A byte falls through empty cells one per cycle to the head, then is registered into the
// result register once it may leave.
// Reset is synchronous and active high; it empties the chain and the result
// register and starts hunting for a header.
// rsp_tready low holds the head; req_tready drops only when every cell is full and the
// head holds, so req_tready follows rsp_tready through the chain in the same cycle.

module sync_header_frame_deframer
   import shfd_pkg::*;
#(
   parameter int MAX_FRAME = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] op (flush)
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [23:8] payload_length
   output logic [3:0]       rsp_tuser,   // [1:0] kind, [2] frame_first, [3] last
   output logic             rsp_tlast    // frame_end
);

   shfd_entry_type  cell_entry [ChainLen];
   logic [ChainLen-1:0] cell_valid;
   logic [ChainLen-1:0] cell_move;
   shfd_entry_type  win [HdrLen];
   shfd_entry_type  req_entry;
   logic            req_xfer;
   logic            drain;
   logic            rsp_valid;
   shfd_result_type rsp;

   // top cell moves: some cell is free, or the head drains this cycle
   assign req_tready = cell_move[ChainLen-1];
   assign req_xfer   = req_tvalid & req_tready;
   assign req_entry  = '{flush: req_tuser, data: req_tdata};

   for (genvar i = 0; i < ChainLen; i++) begin : g_cell
      if (i == ChainLen - 1) begin : g_top
         shfd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .move_in  (cell_move[i-1]),
            .up_entry (req_entry),
            .up_valid (req_xfer),
            .move_out (cell_move[i]),
            .entry    (cell_entry[i]),
            .valid    (cell_valid[i])
         );
      end else if (i == 0) begin : g_head
         shfd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .move_in  (drain),
            .up_entry (cell_entry[i+1]),
            .up_valid (cell_valid[i+1]),
            .move_out (cell_move[i]),
            .entry    (cell_entry[i]),
            .valid    (cell_valid[i])
         );
      end else begin : g_mid
         shfd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .move_in  (cell_move[i-1]),
            .up_entry (cell_entry[i+1]),
            .up_valid (cell_valid[i+1]),
            .move_out (cell_move[i]),
            .entry    (cell_entry[i]),
            .valid    (cell_valid[i])
         );
      end
   end

   // lowest cells form the header window
   for (genvar k = 0; k < HdrLen; k++) begin : g_win
      assign win[k] = cell_entry[k];
   end

   shfd_ctrl #(
      .MAX_FRAME (MAX_FRAME)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .win       (win),
      .win_valid (cell_valid[HdrLen-1:0]),
      .rsp_ready (rsp_tready),
      .drain     (drain),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {rsp.payload_length, rsp.out_byte};
   assign rsp_tuser  = {rsp.last, rsp.frame_first, rsp.kind};
   assign rsp_tlast  = rsp.frame_end;

endmodule

`default_nettype wire
